// ===== rtl/gqm_pkg.sv =====
`timescale 1ns / 1ps
package gqm_pkg;

    // default sizes
    localparam int MAX_COLS_DEF       = 512;
    localparam int CODES_PER_WORD_DEF = 8;

    // fixed field widths
    localparam int VAL_W  = 48;
    localparam int ACT_W  = 32;
    localparam int PROD_W = 37;
    localparam int GCNT_W = 10;

    // weight code decoding
    localparam logic [3:0] CODE_MASK   = 4'hF;
    localparam logic [4:0] CODE_OFFSET = 5'd8;

    // configuration register indexes
    localparam logic [1:0] REG_VEC_LEN    = 2'd0;
    localparam logic [1:0] REG_GROUP_SIZE = 2'd1;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd2;

    // request kinds
    localparam logic REQ_ACT    = 1'b0;
    localparam logic REQ_WEIGHT = 1'b1;

    // saturation limits
    localparam logic signed [VAL_W-1:0] POS48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] NEG48 = 48'sh8000_0000_0000;

    // request into the scale unit
    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] partial;
        logic [15:0]             half;
    } scale_req_t;

endpackage

// ===== rtl/gqm_ram.sv =====
`timescale 1ns / 1ps
module gqm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/gqm_lane.sv =====
`timescale 1ns / 1ps
module gqm_lane
    import gqm_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     use_col,
    input  logic [3:0]               code,
    input  logic signed [ACT_W-1:0]  act,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [4:0]        weight;
    logic signed [PROD_W-1:0] prod_next;

    // code minus offset times activation, zero past the row end
    always_comb
    begin
        weight    = $signed({1'b0, code & CODE_MASK}) - $signed(CODE_OFFSET);
        prod_next = use_col ? PROD_W'(weight * act) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod <= prod_next;
        end
    end

endmodule

// ===== rtl/gqm_merge.sv =====
`timescale 1ns / 1ps
module gqm_merge
    import gqm_pkg::*;
#(
    parameter int CODES_PER_WORD = CODES_PER_WORD_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     clr,
    input  logic signed [PROD_W-1:0] prods [CODES_PER_WORD],
    output logic signed [VAL_W-1:0]  partial
);

    logic signed [VAL_W-1:0] partial_reg;
    logic signed [VAL_W-1:0] partial_next;
    logic signed [VAL_W-1:0] word_sum;

    // lane products summed; the group partial stays far below the 48-bit limit
    always_comb
    begin
        word_sum = '0;
        for (int k = 0; k < CODES_PER_WORD; k++)
        begin
            word_sum = word_sum + VAL_W'(prods[k]);
        end
        partial_next = partial_reg + word_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
        end
        else if (clr)
        begin
            partial_reg <= '0;
        end
        else if (en)
        begin
            partial_reg <= partial_next;
        end
    end

    assign partial = partial_reg;

endmodule

// ===== rtl/gqm_scale.sv =====
`timescale 1ns / 1ps
module gqm_scale
    import gqm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  scale_req_t              req,
    output logic                    term_valid,
    output logic signed [VAL_W-1:0] term
);

    logic [2:0]  v_reg;
    logic [47:0] mag_reg;
    logic [10:0] mant_reg;
    logic [2:0]  shl_reg;
    logic [4:0]  shr_reg;
    logic        neg_reg;
    logic        inf_reg;
    logic        zero_reg;
    logic [58:0] prod_reg;
    logic [2:0]  shl2_reg;
    logic [4:0]  shr2_reg;
    logic        neg2_reg;
    logic        inf2_reg;
    logic        zero2_reg;
    logic signed [VAL_W-1:0] term_reg;

    logic [4:0]  e;
    logic [47:0] mag_next;
    logic [63:0] big;
    logic [63:0] lim;
    logic [63:0] wide;
    logic [63:0] shifted;
    logic signed [VAL_W-1:0] term_next;

    // stage one: split the half float and take the partial's magnitude
    assign e        = req.half[14:10];
    assign mag_next = req.partial[VAL_W-1] ? 48'(-req.partial) : 48'(req.partial);

    // stage three: align the product, round to nearest, saturate
    always_comb
    begin
        big  = 64'd1 << 48;
        wide = {5'd0, prod_reg};
        lim  = big >> shl2_reg;
        if (shr2_reg == 5'd0)
        begin
            shifted = (wide > lim) ? big : (wide << shl2_reg);
        end
        else
        begin
            shifted = (wide + (64'd1 << (shr2_reg - 5'd1))) >> shr2_reg;
        end
        if (inf2_reg)
        begin
            term_next = zero2_reg ? '0 : (neg2_reg ? NEG48 : POS48);
        end
        else if (neg2_reg)
        begin
            term_next = (shifted >= (64'd1 << 47)) ? NEG48 : -$signed(VAL_W'(shifted));
        end
        else
        begin
            term_next = (shifted > 64'(POS48)) ? POS48 : $signed(VAL_W'(shifted));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], req.start};
        end
    end

    always_ff @(posedge clk)
    begin
        // stage one
        mag_reg  <= mag_next;
        mant_reg <= (e == 5'd0) ? {1'b0, req.half[9:0]} : {1'b1, req.half[9:0]};
        shl_reg  <= (e >= 5'd25) ? 3'(e - 5'd25) : 3'd0;
        shr_reg  <= (e == 5'd0) ? 5'd24 : ((e < 5'd25) ? (5'd25 - e) : 5'd0);
        neg_reg  <= req.partial[VAL_W-1] ^ req.half[15];
        inf_reg  <= (e == 5'd31);
        zero_reg <= (req.partial == '0);
        // stage two: magnitude times mantissa
        prod_reg  <= 59'(mag_reg) * 59'(mant_reg);
        shl2_reg  <= shl_reg;
        shr2_reg  <= shr_reg;
        neg2_reg  <= neg_reg;
        inf2_reg  <= inf_reg;
        zero2_reg <= zero_reg;
        // stage three, held until the next request comes through
        if (v_reg[1])
        begin
            term_reg <= term_next;
        end
    end

    assign term_valid = v_reg[2];
    assign term       = term_reg;

endmodule

// ===== rtl/group_quant_int4_matvec_top.sv =====
`timescale 1ns / 1ps
// Group-wise int4 quantized matrix-vector product.
// Input stream: in_tuser selects the beat kind. Kind 0 writes one Q16.16
// activation into the vector store, kind 1 carries one word of packed 4-bit
// weight codes with its group's fp16 scale. Load activations first, then
// stream each row's weight words in column order.
// Output stream: one beat per row with the saturated 48-bit row sum and the
// row index; tlast marks the final row of a pass.
// Config channel: cfg_index 0 vec_len, 1 group_size, 2 row_count; write only
// while idle. cfg_ready is always high.
// Flow: activation beats are taken back to back while idle. A weight word
// passes store read, lane multiply and merge, and when it closes a group
// also the three-stage scale unit and the row-sum update; no new beat is
// taken until it is done. out_tvalid rises once the row sum is complete.
// Reset clears row, group and counter state; the activation store holds
// nothing until written. A result waits in the output register while the
// next row is worked on; the block stops only when a further row result is
// ready and the output beat has not yet been taken.
module group_quant_int4_matvec_top
    import gqm_pkg::*;
#(
    parameter int MAX_COLS       = MAX_COLS_DEF,
    parameter int CODES_PER_WORD = CODES_PER_WORD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_tvalid,
    output logic        in_tready,
    // act_index[8:0], act_value[40:9], weight_codes[72:41], group_scale[88:73]
    input  logic [95:0] in_tdata,
    // req_type[0]
    input  logic        in_tuser,
    output logic        out_tvalid,
    input  logic        out_tready,
    // row_value[47:0], row_index[63:48]
    output logic [63:0] out_tdata,
    output logic        out_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CIDX_W = $clog2(MAX_COLS);
    localparam int POS_W  = $clog2(MAX_COLS + CODES_PER_WORD + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_SC0   = 3'd3;
    localparam logic [2:0] S_SCALE = 3'd4;
    localparam logic [2:0] S_ACC   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [9:0]  vec_len_reg;
    logic [8:0]  group_size_reg;
    logic [15:0] row_count_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [GCNT_W-1:0] gcnt_reg;
    logic [15:0] row_counter_reg;
    logic signed [VAL_W-1:0] row_sum_reg;
    logic [31:0] codes_reg;
    logic [15:0] scale_reg;
    logic [CODES_PER_WORD-1:0] use_reg;
    logic        row_end_reg;
    logic        group_end_reg;
    logic        out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic [15:0] out_index_reg;
    logic        out_last_reg;

    logic        in_acc;
    logic        act_wr;
    logic        wt_acc;
    logic [8:0]  act_index;
    logic [31:0] act_value;
    logic [31:0] weight_codes;
    logic [15:0] group_scale;
    logic [POS_W-1:0]  len_eff;
    logic [GCNT_W-1:0] gs_thr;
    logic [POS_W-1:0]  pos_new;
    logic [GCNT_W-1:0] gcnt_new;
    logic [63:0] codes_wide;
    logic signed [VAL_W:0]   sum_wide;
    logic signed [VAL_W-1:0] sum_sat;
    logic        out_slot;
    logic        acc_done;
    logic [16:0] rc_eff;
    logic        last_row;
    logic signed [ACT_W-1:0]  acts  [CODES_PER_WORD];
    logic signed [PROD_W-1:0] prods [CODES_PER_WORD];
    logic signed [VAL_W-1:0]  partial;
    scale_req_t  scale_req;
    logic        term_valid;
    logic signed [VAL_W-1:0] term;

    // input field unpacking
    assign act_index    = in_tdata[8:0];
    assign act_value    = in_tdata[40:9];
    assign weight_codes = in_tdata[72:41];
    assign group_scale  = in_tdata[88:73];

    assign in_tready = (state_reg == S_IDLE);
    assign in_acc    = in_tvalid && in_tready;
    assign wt_acc    = in_acc && (in_tuser == REQ_WEIGHT);
    assign act_wr    = in_acc && (in_tuser == REQ_ACT)
                       && (32'(act_index) < 32'(MAX_COLS));
    assign cfg_ready = 1'b1;

    // effective row length and group close threshold
    always_comb
    begin
        if (vec_len_reg == 10'd0)
        begin
            len_eff = POS_W'(1);
        end
        else if (32'(vec_len_reg) > 32'(MAX_COLS))
        begin
            len_eff = POS_W'(MAX_COLS);
        end
        else
        begin
            len_eff = POS_W'(vec_len_reg);
        end
        gs_thr = (32'(group_size_reg) < 32'(CODES_PER_WORD)) ?
                 GCNT_W'(CODES_PER_WORD) : GCNT_W'(group_size_reg);
        pos_new  = pos_reg + POS_W'(CODES_PER_WORD);
        gcnt_new = gcnt_reg + GCNT_W'(CODES_PER_WORD);
    end

    assign codes_wide = {32'd0, codes_reg};

    // lanes: one store copy, one multiplier per code of the word
    for (genvar k = 0; k < CODES_PER_WORD; k++)
    begin : g_lane
        logic [POS_W:0]    col;
        logic [ACT_W-1:0]  rd_data;

        assign col     = {1'b0, pos_reg} + (POS_W + 1)'(k);
        assign acts[k] = $signed(rd_data);

        gqm_ram #(
            .WIDTH (ACT_W),
            .DEPTH (MAX_COLS)
        ) u_store (
            .clk     (clk),
            .wr_en   (act_wr),
            .wr_addr (CIDX_W'(act_index)),
            .wr_data (act_value),
            .rd_addr (CIDX_W'(col)),
            .rd_data (rd_data)
        );

        gqm_lane u_lane (
            .clk     (clk),
            .en      (state_reg == S_MUL),
            .use_col (use_reg[k]),
            .code    (codes_wide[4*k +: 4]),
            .act     (acts[k]),
            .prod    (prods[k])
        );

        // column inside the row
        always_ff @(posedge clk)
        begin
            if (wt_acc)
            begin
                use_reg[k] <= (col < {1'b0, len_eff});
            end
        end
    end

    gqm_merge #(
        .CODES_PER_WORD (CODES_PER_WORD)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (state_reg == S_SUM),
        .clr     (state_reg == S_SC0),
        .prods   (prods),
        .partial (partial)
    );

    assign scale_req.start   = (state_reg == S_SC0);
    assign scale_req.partial = partial;
    assign scale_req.half    = scale_reg;

    gqm_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (scale_req),
        .term_valid (term_valid),
        .term       (term)
    );

    // row sum update and row bookkeeping
    always_comb
    begin
        sum_wide = {row_sum_reg[VAL_W-1], row_sum_reg} + {term[VAL_W-1], term};
        if (sum_wide > (VAL_W + 1)'(POS48))
        begin
            sum_sat = POS48;
        end
        else if (sum_wide < $signed({NEG48[VAL_W-1], NEG48}))
        begin
            sum_sat = NEG48;
        end
        else
        begin
            sum_sat = VAL_W'(sum_wide);
        end
        out_slot = !out_valid_reg || out_tready;
        acc_done = (state_reg == S_ACC) && (!row_end_reg || out_slot);
        rc_eff   = (row_count_reg == 16'd0) ? 17'd1 : {1'b0, row_count_reg};
        last_row = ({1'b0, row_counter_reg} + 17'd1) >= rc_eff;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (wt_acc)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = group_end_reg ? S_SC0 : S_IDLE;
            S_SC0:   state_next = S_SCALE;
            S_SCALE:
            begin
                if (term_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (acc_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            vec_len_reg     <= 10'd384;
            group_size_reg  <= 9'd32;
            row_count_reg   <= 16'd1;
            pos_reg         <= '0;
            gcnt_reg        <= '0;
            row_counter_reg <= '0;
            row_sum_reg     <= '0;
            row_end_reg     <= 1'b0;
            group_end_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_VEC_LEN:    vec_len_reg    <= cfg_data[9:0];
                    REG_GROUP_SIZE: group_size_reg <= cfg_data[8:0];
                    REG_ROW_COUNT:  row_count_reg  <= cfg_data;
                    default:        ;
                endcase
            end
            // column and group tracking at weight beat
            if (wt_acc)
            begin
                row_end_reg   <= (pos_new >= len_eff);
                group_end_reg <= (pos_new >= len_eff) || (gcnt_new >= gs_thr);
                pos_reg       <= (pos_new >= len_eff) ? '0 : pos_new;
                gcnt_reg      <= ((pos_new >= len_eff) || (gcnt_new >= gs_thr)) ?
                                 '0 : gcnt_new;
            end
            // output handshake
            if (out_valid_reg && out_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (acc_done)
            begin
                if (row_end_reg)
                begin
                    out_valid_reg   <= 1'b1;
                    row_sum_reg     <= '0;
                    row_counter_reg <= last_row ? 16'd0 : (row_counter_reg + 16'd1);
                end
                else
                begin
                    row_sum_reg <= sum_sat;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (wt_acc)
        begin
            codes_reg <= weight_codes;
            scale_reg <= group_scale;
        end
        if (acc_done && row_end_reg)
        begin
            out_value_reg <= sum_sat;
            out_index_reg <= row_counter_reg;
            out_last_reg  <= last_row;
        end
    end

    assign out_tvalid = out_valid_reg;
    assign out_tdata  = {out_index_reg, out_value_reg};
    assign out_tlast  = out_last_reg;

    // checks
    a_term_in_scale: assert property (@(posedge clk) disable iff (!rst_n)
        term_valid |-> (state_reg == S_SCALE))
        else $error("scale term arrived outside the scale wait");

    a_weight_starts: assert property (@(posedge clk) disable iff (!rst_n)
        wt_acc |=> (state_reg == S_MUL))
        else $error("weight beat did not start the lane multiply");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_done && row_end_reg) |-> (!out_valid_reg || out_tready))
        else $error("row result overwrote a pending output beat");

    a_row_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUM && row_end_reg) |-> group_end_reg)
        else $error("row ended without closing its group");

endmodule
